@@ rtl/chebd_pkg.sv @@
// Shared types and constants of the Chebyshev coefficient derivative block.
package chebd_pkg;

	localparam int IDX_W  = 7;
	localparam int DATA_W = 32;
	localparam int RES_W  = 64;
	localparam int SQ_W   = 2 * IDX_W;
	localparam int WGT_W  = 3 * IDX_W;
	localparam int PROD_W = WGT_W + 1 + DATA_W;
	localparam int OUT_W  = 72;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic             rd_en;
		logic             rd_self;
		logic [IDX_W-1:0] rd_addr;
		logic             acc_clr;
		logic             load_out;
		logic [IDX_W-1:0] n;
		logic             last;
		logic             sec;
		logic             mode2;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/chebyshev_coef_derivative.sv @@
// Top level of the Chebyshev coefficient derivative block.
// Usage:
//   Slave stream: one Q15.16 coefficient per item, in index order; every
//   MAX_COEFS items form one vector, no tlast needed on input.
//   Master stream: MAX_COEFS result items per vector, index order, tlast on
//   the final one. Result has 17 fraction bits.
//   mode_we/mode_wdata set the operator: 0 first derivative, 1 second
//   derivative, 2 or 3 minus four second derivative plus four identity.
//   Write it only while no vector is being worked on.
// Timing:
//   Load takes one item per cycle. Result n costs one memory read for c[n],
//   one read per contributing term (about (MAX_COEFS-n)/2, one per cycle
//   through the single read port and the product multiplier), then the
//   pipeline (stages s1, s2, s3) drains into the accumulator and the result
//   is handed to the output register.
//   Results are computed while the previous one waits in the output register;
//   a stalled receiver holds the result and halts work until it frees.
//   After the final result is registered, input items are taken again.
// Reset: clears the load count, the output valid and sets mode to 1; the
//   coefficient memory is not cleared.
module chebyshev_coef_derivative #(
	parameter int MAX_COEFS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic signed [chebd_pkg::DATA_W-1:0]  s_tdata,   // [31:0] coef_in
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [chebd_pkg::OUT_W-1:0]          m_tdata,   // [63:0] coef_out, [70:64] coef_index
	output logic                                 m_tlast,
	input  logic                                 mode_we,
	input  logic [1:0]                           mode_wdata
);
	import chebd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	chebd_ctrl #(
		.MAX_COEFS(MAX_COEFS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.mode_we    (mode_we),
		.mode_wdata (mode_wdata),
		.sts        (sts),
		.cmd        (cmd)
	);

	chebd_dp #(
		.MAX_COEFS(MAX_COEFS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

@@ rtl/chebd_ctrl.sv @@
// Controller: load sequencing, term issue per result index, drain and result hand-off.
module chebd_ctrl #(
	parameter int MAX_COEFS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic               mode_we,
	input  logic [1:0]         mode_wdata,
	input  chebd_pkg::sts_t    sts,
	output chebd_pkg::cmd_t    cmd
);
	import chebd_pkg::*;

	localparam int AW = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
	localparam int PW = AW + 1;

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]    state_q;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] n_q;
	logic [PW-1:0] p_q;
	logic          self_q;
	logic [1:0]    mode_q;
	logic          accept;
	logic          p_in;
	logic          n_last;

	assign s_tready = (state_q == ST_LOAD);
	assign accept   = s_tvalid & s_tready;
	assign p_in     = (p_q < PW'(MAX_COEFS));
	assign n_last   = (n_q == AW'(MAX_COEFS - 1));

	always_comb begin
		cmd          = '0;
		cmd.wr_en    = accept;
		cmd.wr_addr  = IDX_W'(cnt_q);
		cmd.n        = IDX_W'(n_q);
		cmd.last     = n_last;
		cmd.sec      = mode_q[1] | mode_q[0];
		cmd.mode2    = mode_q[1];
		cmd.acc_clr  = (state_q == ST_LOAD);
		case (state_q)
			ST_ISSUE: begin
				if (self_q) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_self = 1'b1;
					cmd.rd_addr = IDX_W'(n_q);
				end else if (p_in) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = IDX_W'(p_q);
				end
			end
			ST_DRAIN: begin
				if (!sts.busy && sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.acc_clr  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			n_q     <= '0;
			p_q     <= '0;
			self_q  <= 1'b0;
			mode_q  <= 2'd1;
		end else begin
			if (mode_we) begin
				mode_q <= mode_wdata;
			end
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (cnt_q == AW'(MAX_COEFS - 1)) begin
							cnt_q   <= '0;
							n_q     <= '0;
							self_q  <= 1'b1;
							state_q <= ST_ISSUE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_ISSUE: begin
					if (self_q) begin
						self_q <= 1'b0;
						p_q    <= PW'(n_q) + (cmd.sec ? PW'(2) : PW'(1));
					end else if (p_in) begin
						p_q <= p_q + PW'(2);
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (cmd.load_out) begin
						if (n_last) begin
							state_q <= ST_LOAD;
						end else begin
							n_q     <= n_q + 1'b1;
							self_q  <= 1'b1;
							state_q <= ST_ISSUE;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

@@ rtl/chebd_dp.sv @@
// Datapath: coefficient memory, weight and product pipeline, accumulator and output register.
module chebd_dp #(
	parameter int MAX_COEFS = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic signed [chebd_pkg::DATA_W-1:0]   s_tdata,
	input  chebd_pkg::cmd_t                       cmd,
	output chebd_pkg::sts_t                       sts,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [chebd_pkg::OUT_W-1:0]           m_tdata,
	output logic                                  m_tlast
);
	import chebd_pkg::*;

	localparam int AW = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;

	logic signed [DATA_W-1:0] mem [MAX_COEFS];

	logic                     v_s1, self_s1, v_s2, v_s3;
	logic signed [DATA_W-1:0] rd_s1, c_s2;
	logic [IDX_W-1:0]         p_s1;
	logic [SQ_W-1:0]          pp_s1, nn_s1, diff_s1;
	logic [WGT_W-1:0]         w_s2;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [RES_W-1:0]  acc_q, cn_q, deriv, res;
	logic [RES_W-1:0]         out_data_q;
	logic [IDX_W-1:0]         out_idx_q;
	logic                     out_last_q, out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr[AW-1:0]] <= s_tdata;
		end
		rd_s1 <= mem[cmd.rd_addr[AW-1:0]];
		p_s1  <= cmd.rd_addr;
		pp_s1 <= SQ_W'(cmd.rd_addr) * SQ_W'(cmd.rd_addr);
		nn_s1 <= SQ_W'(cmd.n) * SQ_W'(cmd.n);
	end

	assign diff_s1 = pp_s1 - nn_s1;

	always_ff @(posedge clk) begin
		c_s2    <= rd_s1;
		w_s2    <= cmd.sec ? WGT_W'(p_s1) * WGT_W'(diff_s1) : WGT_W'({p_s1, 1'b0});
		prod_s3 <= $signed({1'b0, w_s2}) * c_s2;
		if (self_s1) begin
			cn_q <= RES_W'(rd_s1);
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + RES_W'(prod_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			self_s1 <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			v_s1    <= cmd.rd_en & ~cmd.rd_self;
			self_s1 <= cmd.rd_en & cmd.rd_self;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
		end
	end

	assign deriv = (cmd.n == '0) ? acc_q : (acc_q <<< 1);
	assign res   = cmd.mode2 ? ((cn_q <<< 3) - (deriv <<< 2)) : deriv;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= res;
			out_idx_q  <= cmd.n;
			out_last_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.busy     = v_s1 | self_s1 | v_s2 | v_s3;
	assign sts.out_free = ~out_valid_q | m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_idx_q, out_data_q};
	assign m_tlast  = out_last_q;

endmodule

@@ rtl/chebd_chk.sv @@
// Port-level checker for the Chebyshev coefficient derivative block, with its bind.
module chebd_chk #(
	parameter int MAX_COEFS = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[70:64] == 7'(MAX_COEFS - 1))))
		else $error("tlast does not match final index");

	a_no_load_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input taken while a vector is in progress");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[71])
		else $error("padding bit set");

endmodule

bind chebyshev_coef_derivative chebd_chk #(
	.MAX_COEFS(MAX_COEFS)
) u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

@@ tb/chebyshev_coef_derivative_tb.sv @@
// Testbench for chebyshev_coef_derivative: streams coefficient vectors and checks every result.
`timescale 1ns / 100ps

module chebyshev_coef_derivative_tb;

	import chebd_pkg::*;

	localparam int NCOEF       = 64;
	localparam int NVEC        = 5;
	localparam int MAX_GAP     = 17;
	localparam int SETTLE      = 16;
	localparam int TAIL_CYCLES = 200;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX  = 10;

	typedef enum logic [1:0] {
		MODE_FIRST   = 2'd0,
		MODE_SECOND  = 2'd1,
		MODE_TAU     = 2'd2,
		MODE_TAU_ALT = 2'd3
	} deriv_mode_e;

	typedef struct {
		logic signed [DATA_W-1:0] coef;
		int                       gap;
		bit                       set_mode;
		deriv_mode_e              mode_val;
	} coef_item_t;

	typedef struct {
		logic signed [RES_W-1:0] value;
		logic [IDX_W-1:0]        idx;
		logic                    last;
	} coef_result_t;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     s_tvalid   = 1'b0;
	logic                     s_tready;
	logic signed [DATA_W-1:0] s_tdata    = '0;
	logic                     m_tvalid;
	logic                     m_tready   = 1'b0;
	logic [OUT_W-1:0]         m_tdata;
	logic                     m_tlast;
	logic                     mode_we    = 1'b0;
	logic [1:0]               mode_wdata = 2'd0;

	coef_item_t               pending[$];
	coef_result_t             result_q[$];
	logic signed [DATA_W-1:0] coef_mem[NCOEF];
	int                       load_cnt       = 0;
	deriv_mode_e              op_mode        = MODE_SECOND;
	int                       wait_cnt       = 0;
	int                       quiet_cnt      = 0;
	int                       stall_left     = 0;
	bit                       rx_burst       = 1'b0;
	int                       fail_cnt       = 0;
	int                       coefs_loaded   = 0;
	int                       vectors_done   = 0;
	int                       results_seen   = 0;
	int                       cycle_cnt      = 0;
	logic [3:0]               modes_seen     = '0;

	chebyshev_coef_derivative #(
		.MAX_COEFS(NCOEF)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.mode_we   (mode_we),
		.mode_wdata(mode_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic signed [DATA_W-1:0] corner_coef(int i);
		case (i % 8)
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return 32'sh0000_0000;
			3: return 32'sh0000_0001;
			4: return 32'shffff_ffff;
			5: return 32'sh0001_0000;
			6: return 32'sh5555_5555;
			default: return 32'shaaaa_aaaa;
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_coef();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 32'h3ffff) - 32'h20000;
			1: return corner_coef($urandom_range(0, 7));
			default: return $urandom;
		endcase
	endfunction

	// sum of weighted coefficients above n with the parity of the operator, scaled to 17 fraction bits
	function automatic longint deriv_sum(int n, bit second);
		longint acc;
		longint w;
		acc = 0;
		for (int p = n + 1; p < NCOEF; p++) begin
			if (second) begin
				if (p < n + 2 || ((p + n) % 2) != 0)
					continue;
				w = longint'(p) * (longint'(p) * p - longint'(n) * n);
			end else begin
				if (((p + n) % 2) == 0)
					continue;
				w = 2 * longint'(p);
			end
			acc += w * longint'(coef_mem[p]);
		end
		if (n != 0)
			acc = acc << 1;
		return acc;
	endfunction

	task automatic predict_vector();
		coef_result_t r;
		for (int n = 0; n < NCOEF; n++) begin
			if (op_mode == MODE_FIRST)
				r.value = deriv_sum(n, 1'b0);
			else if (op_mode == MODE_SECOND)
				r.value = deriv_sum(n, 1'b1);
			else
				r.value = -4 * deriv_sum(n, 1'b1) + 8 * longint'(coef_mem[n]);
			r.idx  = n[IDX_W-1:0];
			r.last = (n == NCOEF - 1);
			result_q.push_back(r);
		end
		modes_seen[op_mode] = 1'b1;
	endtask

	task automatic store_coef(logic signed [DATA_W-1:0] c);
		coef_mem[load_cnt] = c;
		load_cnt++;
		coefs_loaded++;
		if (load_cnt == NCOEF) begin
			load_cnt = 0;
			vectors_done++;
			predict_vector();
		end
	endtask

	always @(posedge clk) begin
		bit valid_nxt;
		bit we_nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			mode_we  <= 1'b0;
			wait_cnt  = 0;
			quiet_cnt = 0;
		end else begin
			valid_nxt = s_tvalid;
			we_nxt    = 1'b0;
			if (s_tvalid && s_tready) begin
				store_coef(s_tdata);
				valid_nxt = 1'b0;
			end
			if (result_q.size() == 0 && !valid_nxt && load_cnt == 0)
				quiet_cnt++;
			else
				quiet_cnt = 0;
			if (!valid_nxt && pending.size() > 0) begin
				if (pending[0].set_mode) begin
					// hold the write until the block has drained
					if (quiet_cnt >= SETTLE) begin
						we_nxt = 1'b1;
						mode_wdata <= pending[0].mode_val;
						op_mode = pending[0].mode_val;
						pending[0].set_mode = 1'b0;
						wait_cnt = 0;
					end
				end else if (wait_cnt < pending[0].gap) begin
					wait_cnt++;
				end else begin
					s_tdata <= pending[0].coef;
					valid_nxt = 1'b1;
					void'(pending.pop_front());
					wait_cnt = 0;
				end
			end
			s_tvalid <= valid_nxt;
			mode_we  <= we_nxt;
		end
	end

	always @(posedge clk) begin
		coef_result_t             want;
		logic signed [RES_W-1:0]  got_val;
		logic [IDX_W-1:0]         got_idx;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_val = m_tdata[RES_W-1:0];
				got_idx = m_tdata[RES_W +: IDX_W];
				results_seen++;
				if (result_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= REPORT_MAX)
						$display("unexpected result: value %0d index %0d last %0b",
							got_val, got_idx, m_tlast);
				end else begin
					want = result_q.pop_front();
					if (got_val !== want.value || got_idx !== want.idx || m_tlast !== want.last) begin
						fail_cnt++;
						if (fail_cnt <= REPORT_MAX)
							$display("result mismatch: expected %0d idx %0d last %0b, got %0d idx %0d last %0b",
								want.value, want.idx, want.last, got_val, got_idx, m_tlast);
					end
				end
				if (results_seen % 16 == 0)
					rx_burst = ($urandom_range(0, 3) == 0);
				stall_left = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			m_tready <= (stall_left == 0);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("cycle limit hit with %0d items queued and %0d results outstanding",
				pending.size(), result_q.size());
			$display("chebyshev_coef_derivative: mismatch");
			$finish;
		end
	end

	initial begin
		coef_item_t it;
		bit         tx_burst;
		tx_burst = 1'b0;
		for (int v = 0; v < NVEC; v++) begin
			for (int i = 0; i < NCOEF; i++) begin
				if (i % 16 == 0)
					tx_burst = ($urandom_range(0, 3) == 0);
				it.gap      = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
				it.set_mode = (i == 0 && v > 0);
				case (v)
					1: it.mode_val = MODE_FIRST;
					2: it.mode_val = MODE_TAU;
					3: it.mode_val = MODE_TAU_ALT;
					default: it.mode_val = MODE_SECOND;
				endcase
				case (v)
					0: it.coef = (i < 24) ? corner_coef(i) : pick_coef();
					1: it.coef = 32'sh7fff_ffff;
					2: it.coef = 32'sh8000_0000;
					default: it.coef = pick_coef();
				endcase
				pending.push_back(it);
			end
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(posedge clk);
		while (pending.size() != 0 || s_tvalid || result_q.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("loaded %0d coefficients as %0d vectors, checked %0d results",
			coefs_loaded, vectors_done, results_seen);
		$display("operator modes exercised (bit per mode value): %b", modes_seen);
		if (fail_cnt == 0)
			$display("chebyshev_coef_derivative: match");
		else
			$display("chebyshev_coef_derivative: mismatch");
		$finish;
	end

endmodule
